@@ design/qsl_pkg.sv @@
// Shared types, widths and constant tables for the quaternion slerp unit.
package qsl_pkg;

    localparam int DEF_ANGLE_ITERATIONS = 16;
    localparam int ATAN_STEPS           = 24;
    localparam int SQRT_STEPS           = 16;

    localparam int CW = 34;           // CORDIC datapath width, signed Q30 with headroom
    localparam int DW = CW + 15;      // divider dividend width (|sin| << 15)
    localparam int WW = DW + 1;       // signed weight width
    localparam int PW = 16 + WW;      // component times weight

    localparam logic [14:0] THR_RESET  = 15'h7FFF;
    localparam logic [16:0] BLEND_ONE  = 17'h10000;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    // Per-word side data carried down the whole pipeline.
    typedef struct packed {
        logic [3:0][15:0] qa;
        logic [3:0][15:0] qb;
        logic [16:0]      t;
        logic             linear;
        logic             flip;
        logic [14:0]      cc;
        logic [15:0]      s;
    } side_t;

    // Truncated arctangent table, Q30.
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ design/quaternion_slerp_unit.sv @@
// Quaternion slerp unit: fully pipelined spherical / linear blend of two quaternions.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+------------------------------------
//  in      | sink      | in_valid / in_stall     | a_x..a_w, b_x..b_w, blend
//  out     | source    | out_valid / out_stall   | r_x..r_w, used_linear
//  cfg     | sink      | cfg_write_en            | cfg_write_data (lerp threshold)
//
// One word enters per cycle while the output is not held; 74 + 2*ANGLE_ITERATIONS
// register stages (106 at 16): 4 setup stages, 16 square-root digit stages, two
// CORDIC chains of ANGLE_ITERATIONS stages each, 2 angle-scaling stages, 49
// restoring-divider stages and 3 weighting/output stages.
// All stages advance together; a stalled output word freezes the whole pipe, so
// in_stall follows out_valid && out_stall. Reset clears the valid bits and loads the
// threshold with its reset value; data registers are not reset.
module quaternion_slerp_unit
    import qsl_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = DEF_ANGLE_ITERATIONS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [14:0]        cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] a_w,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    input  logic signed [15:0] b_w,
    input  logic [16:0]        blend,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] r_x,
    output logic signed [15:0] r_y,
    output logic signed [15:0] r_z,
    output logic signed [15:0] r_w,
    output logic               used_linear
);

    // Stage positions along the pipe.
    localparam int P_PROD = 1;
    localparam int P_COS  = 2;
    localparam int P_N    = 3;
    localparam int P_SQ0  = 4;
    localparam int P_AN0  = P_SQ0 + SQRT_STEPS;
    localparam int P_MUL  = P_AN0 + ANGLE_ITERATIONS;
    localparam int P_Z    = P_MUL + 1;
    localparam int P_SIN0 = P_Z + 1;
    localparam int P_DIV0 = P_SIN0 + ANGLE_ITERATIONS;
    localparam int P_W    = P_DIV0 + DW;
    localparam int P_PR   = P_W + 1;
    localparam int P_OUT  = P_PR + 1;
    localparam int DEPTH  = P_OUT + 1;
    localparam int AI     = ANGLE_ITERATIONS;

    logic en;
    logic [14:0] thr_reg;

    logic  valid_reg [DEPTH];
    side_t side_reg  [P_OUT];
    side_t side_next [P_OUT];

    // whole pipe moves unless the output word is held
    assign en        = !(valid_reg[DEPTH-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_write_en)
        begin
            thr_reg <= cfg_write_data;
        end
    end

    // ---------------- valid bits ----------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_valid
        logic valid_in;
        if (i == 0)
        begin : g_first
            assign valid_in = in_valid;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[i-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end
    end

    // ---------------- stage 0: capture, clamp blend ----------------
    always_comb
    begin
        side_next[0]    = '0;
        side_next[0].qa = {a_w, a_z, a_y, a_x};
        side_next[0].qb = {b_w, b_z, b_y, b_x};
        side_next[0].t  = (blend > BLEND_ONE) ? BLEND_ONE : blend;
    end

    // ---------------- stage 1: component products ----------------
    logic signed [31:0] prod_reg [4];
    for (genvar k = 0; k < 4; k++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[k] <= $signed(side_reg[0].qa[k]) * $signed(side_reg[0].qb[k]);
            end
        end
    end

    // ---------------- stage 2: dot, short arc, branch select ----------------
    logic signed [33:0] dot;
    logic [33:0]        dot_abs;
    logic [18:0]        cosq;
    logic               cos_linear;
    always_comb
    begin
        dot = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        dot_abs    = dot[33] ? 34'(-dot) : 34'(dot);
        cosq       = dot_abs[33:15];
        cos_linear = cosq > {4'b0, thr_reg};
    end

    // ---------------- stage 3: 1 - cos^2 ----------------
    logic [29:0] cc_sq;
    logic [30:0] n_reg;
    assign cc_sq = side_reg[P_COS].cc * side_reg[P_COS].cc;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= 31'h4000_0000 - {1'b0, cc_sq};
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [30:0] sq_n_reg    [SQRT_STEPS];
    logic [17:0] sq_rem_reg  [SQRT_STEPS];
    logic [15:0] sq_root_reg [SQRT_STEPS];
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [30:0] n_in;
        logic [17:0] rem_in;
        logic [15:0] root_in;
        logic [31:0] n32;
        logic [19:0] trial;
        logic [19:0] cur;
        if (k == 0)
        begin : g_first
            assign n_in    = n_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign n_in    = sq_n_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
        end
        assign n32   = {1'b0, n_in};
        assign cur   = {rem_in, n32[31-2*k -: 2]};
        assign trial = {2'b0, root_in, 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_n_reg[k] <= n_in;
                if (cur >= trial)
                begin
                    sq_rem_reg[k]  <= 18'(cur - trial);
                    sq_root_reg[k] <= {root_in[14:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k]  <= cur[17:0];
                    sq_root_reg[k] <= {root_in[14:0], 1'b0};
                end
            end
        end
    end

    // ---------------- vectoring CORDIC: theta = atan2(s, cos) ----------------
    logic signed [CW-1:0] ax_reg [AI];
    logic signed [CW-1:0] ay_reg [AI];
    logic signed [CW-1:0] az_reg [AI];
    for (genvar i = 0; i < AI; i++)
    begin : g_angle
        logic signed [CW-1:0] x_in, y_in, z_in, at;
        if (i == 0)
        begin : g_first
            assign x_in = $signed({4'b0, side_reg[P_AN0-1].cc, 15'b0});
            assign y_in = $signed({3'b0, sq_root_reg[SQRT_STEPS-1], 15'b0});
            assign z_in = '0;
        end
        else
        begin : g_next
            assign x_in = ax_reg[i-1];
            assign y_in = ay_reg[i-1];
            assign z_in = az_reg[i-1];
        end
        assign at = $signed({2'b0, atan_q30(5'(i))});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_in[CW-1])
                begin
                    ax_reg[i] <= x_in + (y_in >>> i);
                    ay_reg[i] <= y_in - (x_in >>> i);
                    az_reg[i] <= z_in + at;
                end
                else
                begin
                    ax_reg[i] <= x_in - (y_in >>> i);
                    ay_reg[i] <= y_in + (x_in >>> i);
                    az_reg[i] <= z_in - at;
                end
            end
        end
    end

    // ---------------- t * theta ----------------
    logic signed [CW+17:0] mul_reg;
    logic signed [CW-1:0]  ang_reg;
    logic signed [CW-1:0]  za_reg;
    logic signed [CW-1:0]  zb_reg;
    logic signed [CW-1:0]  part;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= az_reg[AI-1] * $signed({1'b0, side_reg[P_MUL-1].t});
            ang_reg <= az_reg[AI-1];
        end
    end
    assign part = $signed(mul_reg[CW+15:16]);   // floor shift by 16
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zb_reg <= part;
            za_reg <= ang_reg - part;
        end
    end

    // ---------------- rotation CORDIC, two lanes: 0 -> wa, 1 -> wb ----------------
    logic signed [CW-1:0] sx_reg [2][AI];
    logic signed [CW-1:0] sy_reg [2][AI];
    logic signed [CW-1:0] sz_reg [2][AI];
    for (genvar l = 0; l < 2; l++)
    begin : g_sin_lane
        for (genvar i = 0; i < AI; i++)
        begin : g_sin
            logic signed [CW-1:0] x_in, y_in, z_in, at;
            if (i == 0)
            begin : g_first
                assign x_in = $signed({2'b0, CORDIC_GAIN});
                assign y_in = '0;
                assign z_in = (l == 0) ? za_reg : zb_reg;
            end
            else
            begin : g_next
                assign x_in = sx_reg[l][i-1];
                assign y_in = sy_reg[l][i-1];
                assign z_in = sz_reg[l][i-1];
            end
            assign at = $signed({2'b0, atan_q30(5'(i))});
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!z_in[CW-1])
                    begin
                        sx_reg[l][i] <= x_in - (y_in >>> i);
                        sy_reg[l][i] <= y_in + (x_in >>> i);
                        sz_reg[l][i] <= z_in - at;
                    end
                    else
                    begin
                        sx_reg[l][i] <= x_in + (y_in >>> i);
                        sy_reg[l][i] <= y_in - (x_in >>> i);
                        sz_reg[l][i] <= z_in + at;
                    end
                end
            end
        end
    end

    // ---------------- restoring divide (sin << 15) / s, one bit per stage ----------------
    logic [DW-1:0] dv_reg  [2][DW];
    logic [15:0]   rem_reg [2][DW];
    logic          neg_reg [2][DW];
    for (genvar l = 0; l < 2; l++)
    begin : g_div_lane
        for (genvar k = 0; k < DW; k++)
        begin : g_div
            logic [DW-1:0] dv_in;
            logic [15:0]   rem_in;
            logic          neg_in;
            logic [16:0]   cur;
            logic [16:0]   den;
            logic          ge;
            if (k == 0)
            begin : g_first
                logic signed [CW-1:0] sv;
                logic [CW-1:0]        mag;
                assign sv     = sy_reg[l][AI-1];
                assign mag    = sv[CW-1] ? CW'(-sv) : CW'(sv);
                assign dv_in  = {mag, 15'b0};
                assign rem_in = '0;
                assign neg_in = sv[CW-1];
            end
            else
            begin : g_next
                assign dv_in  = dv_reg[l][k-1];
                assign rem_in = rem_reg[l][k-1];
                assign neg_in = neg_reg[l][k-1];
            end
            assign cur = {rem_in, dv_in[DW-1]};
            assign den = {1'b0, side_reg[P_DIV0+k-1].s};
            assign ge  = cur >= den;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg[l][k] <= neg_in;
                    dv_reg[l][k]  <= {dv_in[DW-2:0], ge};
                    rem_reg[l][k] <= ge ? 16'(cur - den) : cur[15:0];
                end
            end
        end
    end

    // ---------------- weight select ----------------
    logic signed [WW-1:0] wa_reg, wb_reg;
    logic signed [WW-1:0] wa_sph, wb_sph, wb_lin, wa_lin, wb_sel;
    side_t                sw;
    always_comb
    begin
        sw     = side_reg[P_W-1];
        wa_sph = neg_reg[0][DW-1] ? -$signed({1'b0, dv_reg[0][DW-1]})
                                  :  $signed({1'b0, dv_reg[0][DW-1]});
        wb_sph = neg_reg[1][DW-1] ? -$signed({1'b0, dv_reg[1][DW-1]})
                                  :  $signed({1'b0, dv_reg[1][DW-1]});
        wb_lin = $signed(WW'({sw.t, 14'b0}));
        wa_lin = $signed(WW'(32'h4000_0000)) - wb_lin;
        wb_sel = sw.linear ? wb_lin : wb_sph;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wa_reg <= sw.linear ? wa_lin : wa_sph;
            wb_reg <= sw.flip ? -wb_sel : wb_sel;
        end
    end

    // ---------------- weighted products ----------------
    logic signed [PW-1:0] pa_reg [4];
    logic signed [PW-1:0] pb_reg [4];
    for (genvar k = 0; k < 4; k++)
    begin : g_wprod
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg[k] <= $signed(side_reg[P_PR-1].qa[k]) * wa_reg;
                pb_reg[k] <= $signed(side_reg[P_PR-1].qb[k]) * wb_reg;
            end
        end
    end

    // ---------------- round, shift, saturate ----------------
    logic signed [15:0] res_reg [4];
    logic               lin_reg;
    for (genvar k = 0; k < 4; k++)
    begin : g_out
        logic signed [PW:0]    acc;
        logic signed [PW-30:0] rs;
        logic signed [15:0]    sat;
        always_comb
        begin
            acc = (PW+1)'(pa_reg[k]) + (PW+1)'(pb_reg[k])
                  + $signed((PW+1)'(32'h2000_0000));
            rs  = $signed(acc[PW:30]);
            if (rs > $signed((PW-29)'(32767)))
            begin
                sat = 16'sh7FFF;
            end
            else if (rs < -$signed((PW-29)'(32768)))
            begin
                sat = -16'sh8000;
            end
            else
            begin
                sat = rs[15:0];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[k] <= sat;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg <= side_reg[P_PR].linear;
        end
    end

    assign r_x         = res_reg[0];
    assign r_y         = res_reg[1];
    assign r_z         = res_reg[2];
    assign r_w         = res_reg[3];
    assign used_linear = lin_reg;

    // ---------------- side data line ----------------
    for (genvar i = 1; i < P_OUT; i++)
    begin : g_side_next
        always_comb
        begin
            side_next[i] = side_reg[i-1];
            if (i == P_COS)
            begin
                side_next[i].linear = cos_linear;
                side_next[i].flip   = dot[33];
                side_next[i].cc     = cos_linear ? 15'd0 : cosq[14:0];
            end
            if (i == P_AN0)
            begin
                side_next[i].s = sq_root_reg[SQRT_STEPS-1];
            end
        end
    end
    for (genvar i = 0; i < P_OUT; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

endmodule

@@ design/qsl_checker.sv @@
// Port-level checker for the quaternion slerp unit, with its bind.
module qsl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] r_x,
    input logic signed [15:0] r_y,
    input logic signed [15:0] r_z,
    input logic signed [15:0] r_w,
    input logic               used_linear
);

    // input back-pressure comes only from a held output word
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without held output word");

    // a frozen pipe does not create or drop an output word
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(out_valid))
        else $error("out_valid moved while pipe frozen");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(r_x) && $stable(r_y)
            && $stable(r_z) && $stable(r_w) && $stable(used_linear)))
        else $error("held output word changed");

endmodule

bind quaternion_slerp_unit qsl_checker u_qsl_checker (.*);
